// ----- rtl/tool_radius_coverage_counter_core_macros.svh -----
// ----------------------------------------------------------------------------
// Tool radius coverage counter assertion macros
// Shared concurrent assertion forms for the coverage counter RTL.
// ----------------------------------------------------------------------------
`ifndef TOOL_RADIUS_COVERAGE_COUNTER_CORE_MACROS_SVH
`define TOOL_RADIUS_COVERAGE_COUNTER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TRCC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("coverage counter assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define TRCC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("coverage counter assertion failed");

`endif

// ----- rtl/trcc_pkg.sv -----
// ----------------------------------------------------------------------------
// Tool radius coverage counter package
// Request function codes shared by the channel interfaces and the core.
// ----------------------------------------------------------------------------
package trcc_pkg;

   localparam int FUNC_WIDTH = 2;

   typedef logic [FUNC_WIDTH-1:0] func_type;

   localparam func_type FUNC_START = 2'd0;
   localparam func_type FUNC_WAYPOINT = 2'd1;
   localparam func_type FUNC_END = 2'd2;
   localparam func_type FUNC_CLEAR = 2'd3;

endpackage

// ----- rtl/trcc_channel_if.sv -----
// ----------------------------------------------------------------------------
// Tool radius coverage counter channels
// Valid/ready request and response channels with their payloads.
// ----------------------------------------------------------------------------
interface trcc_req_if
   import trcc_pkg::*;
#(
   parameter int COORD_WIDTH = 24
);
   logic                          valid;
   logic                          ready;
   func_type                      func;
   logic signed [COORD_WIDTH-1:0] pos_x;
   logic signed [COORD_WIDTH-1:0] pos_y;
   logic signed [COORD_WIDTH-1:0] pos_z;

   modport source (output valid, func, pos_x, pos_y, pos_z, input ready);
   modport sink (input valid, func, pos_x, pos_y, pos_z, output ready);
endinterface

interface trcc_rsp_if #(
   parameter int COUNT_WIDTH = 16,
   parameter int TOTAL_WIDTH = 20
);
   logic                   valid;
   logic                   ready;
   logic                   point_covered;
   logic [COUNT_WIDTH-1:0] hit_count;
   logic [COUNT_WIDTH-1:0] run_count;
   logic [TOTAL_WIDTH-1:0] points_seen;
   logic [TOTAL_WIDTH-1:0] points_hit;
   logic [COUNT_WIDTH-1:0] max_runs;

   modport source (output valid, point_covered, hit_count, run_count, points_seen,
                   points_hit, max_runs, input ready);
   modport sink (input valid, point_covered, hit_count, run_count, points_seen,
                 points_hit, max_runs, output ready);
endinterface

// ----- rtl/trcc_cover_test.sv -----
// ----------------------------------------------------------------------------
// Tool radius coverage test
// Decides whether a waypoint lies within the tool radius of the stored point.
// ----------------------------------------------------------------------------
module trcc_cover_test #(
   parameter int COORD_WIDTH = 24
) (
   input  logic [COORD_WIDTH-1:0]       point_x,
   input  logic [COORD_WIDTH-1:0]       point_y,
   input  logic [COORD_WIDTH-1:0]       point_z,
   input  logic [COORD_WIDTH-1:0]       pos_x,
   input  logic [COORD_WIDTH-1:0]       pos_y,
   input  logic [COORD_WIDTH-1:0]       pos_z,
   input  logic [COORD_WIDTH-2:0]       radius,
   input  logic [2*(COORD_WIDTH-1)-1:0] radius_sq,
   output logic                         hit
);

   localparam int RW = COORD_WIDTH - 1;
   localparam int DW = COORD_WIDTH + 1;
   localparam int SQ = 2 * RW;
   localparam int SUMW = SQ + 2;

   logic [DW-1:0]          diff_x, diff_y, diff_z;
   logic [DW-1:0]          mag_x, mag_y, mag_z;
   logic [COORD_WIDTH-1:0] abs_x, abs_y, abs_z;
   logic [SQ-1:0]          ext_x, ext_y, ext_z;
   logic [SQ-1:0]          sq_x, sq_y, sq_z;
   logic [SUMW-1:0]        dist_sq;
   logic                   too_far;

   assign diff_x = {pos_x[COORD_WIDTH-1], pos_x} - {point_x[COORD_WIDTH-1], point_x};
   assign diff_y = {pos_y[COORD_WIDTH-1], pos_y} - {point_y[COORD_WIDTH-1], point_y};
   assign diff_z = {pos_z[COORD_WIDTH-1], pos_z} - {point_z[COORD_WIDTH-1], point_z};

   assign mag_x = diff_x[DW-1] ? (DW'(0) - diff_x) : diff_x;
   assign mag_y = diff_y[DW-1] ? (DW'(0) - diff_y) : diff_y;
   assign mag_z = diff_z[DW-1] ? (DW'(0) - diff_z) : diff_z;

   assign abs_x = mag_x[COORD_WIDTH-1:0];
   assign abs_y = mag_y[COORD_WIDTH-1:0];
   assign abs_z = mag_z[COORD_WIDTH-1:0];

   // Any axis beyond the radius rules the waypoint out, so squares stay narrow.
   assign too_far = (abs_x > {1'b0, radius}) || (abs_y > {1'b0, radius})
                    || (abs_z > {1'b0, radius});

   assign ext_x = SQ'(abs_x[RW-1:0]);
   assign ext_y = SQ'(abs_y[RW-1:0]);
   assign ext_z = SQ'(abs_z[RW-1:0]);

   assign sq_x = ext_x * ext_x;
   assign sq_y = ext_y * ext_y;
   assign sq_z = ext_z * ext_z;

   assign dist_sq = SUMW'(sq_x) + SUMW'(sq_y) + SUMW'(sq_z);

   assign hit = !too_far && (dist_sq <= SUMW'(radius_sq));

endmodule

// ----- rtl/tool_radius_coverage_counter_core.sv -----
// ----------------------------------------------------------------------------
// Tool radius coverage counter core
// An accepted end request passes through one input register and one result
// register. Synchronous reset clears all state but the payload registers.
// Throughput: one request per cycle; only an end request waits, and only while
// the previous result has not been taken.
// ----------------------------------------------------------------------------
module tool_radius_coverage_counter_core
   import trcc_pkg::*;
#(
   parameter int COORD_WIDTH = 24,
   parameter int COUNT_WIDTH = 16,
   parameter int TOTAL_WIDTH = 20
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [COORD_WIDTH-2:0] csr_wdata,
   trcc_req_if.sink               req_chan,
   trcc_rsp_if.source             rsp_chan
);

   `include "tool_radius_coverage_counter_core_macros.svh"

   localparam int RW = COORD_WIDTH - 1;
   localparam int SQ = 2 * RW;

   logic [RW-1:0]          radius_ff;
   logic [SQ-1:0]          radius_sq_ff;

   logic                   item_valid_ff, item_valid_in;
   func_type               item_func_ff;
   logic [COORD_WIDTH-1:0] item_x_ff, item_y_ff, item_z_ff;

   logic [COORD_WIDTH-1:0] point_x_ff, point_x_in;
   logic [COORD_WIDTH-1:0] point_y_ff, point_y_in;
   logic [COORD_WIDTH-1:0] point_z_ff, point_z_in;
   logic                   prev_hit_ff, prev_hit_in;
   logic [COUNT_WIDTH-1:0] hits_ff, hits_in;
   logic [COUNT_WIDTH-1:0] runs_ff, runs_in;
   logic [TOTAL_WIDTH-1:0] total_points_ff, total_points_in;
   logic [TOTAL_WIDTH-1:0] total_covered_ff, total_covered_in;
   logic [COUNT_WIDTH-1:0] largest_runs_ff, largest_runs_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_covered_ff;
   logic [COUNT_WIDTH-1:0] rsp_hits_ff, rsp_runs_ff, rsp_max_runs_ff;
   logic [TOTAL_WIDTH-1:0] rsp_seen_ff, rsp_hit_points_ff;

   logic                   is_end, rsp_free, item_go, req_take, wp_hit;

   trcc_cover_test #(
      .COORD_WIDTH(COORD_WIDTH)
   ) u_cover_test (
      .point_x  (point_x_ff),
      .point_y  (point_y_ff),
      .point_z  (point_z_ff),
      .pos_x    (item_x_ff),
      .pos_y    (item_y_ff),
      .pos_z    (item_z_ff),
      .radius   (radius_ff),
      .radius_sq(radius_sq_ff),
      .hit      (wp_hit)
   );

   assign is_end = (item_func_ff == FUNC_END);
   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;
   assign item_go = item_valid_ff && (!is_end || rsp_free);
   assign req_chan.ready = !item_valid_ff || item_go;
   assign req_take = req_chan.valid && req_chan.ready;

   assign item_valid_in = req_take || (item_valid_ff && !item_go);
   assign rsp_valid_in = (item_go && is_end) || (rsp_valid_ff && !rsp_chan.ready);

   always_comb begin
      point_x_in = point_x_ff;
      point_y_in = point_y_ff;
      point_z_in = point_z_ff;
      prev_hit_in = prev_hit_ff;
      hits_in = hits_ff;
      runs_in = runs_ff;
      total_points_in = total_points_ff;
      total_covered_in = total_covered_ff;
      largest_runs_in = largest_runs_ff;
      if (item_go) begin
         unique case (item_func_ff)
            FUNC_START: begin
               point_x_in = item_x_ff;
               point_y_in = item_y_ff;
               point_z_in = item_z_ff;
               prev_hit_in = 1'b0;
               hits_in = '0;
               runs_in = '0;
            end
            FUNC_WAYPOINT: begin
               prev_hit_in = wp_hit;
               if (wp_hit && !(&hits_ff)) begin
                  hits_in = hits_ff + COUNT_WIDTH'(1);
               end
               if (wp_hit && !prev_hit_ff && !(&runs_ff)) begin
                  runs_in = runs_ff + COUNT_WIDTH'(1);
               end
            end
            FUNC_END: begin
               if (!(&total_points_ff)) begin
                  total_points_in = total_points_ff + TOTAL_WIDTH'(1);
               end
               if ((hits_ff != '0) && !(&total_covered_ff)) begin
                  total_covered_in = total_covered_ff + TOTAL_WIDTH'(1);
               end
               if (runs_ff > largest_runs_ff) begin
                  largest_runs_in = runs_ff;
               end
            end
            FUNC_CLEAR: begin
               total_points_in = '0;
               total_covered_in = '0;
               largest_runs_in = '0;
            end
            default: begin
               prev_hit_in = prev_hit_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= '0;
         radius_sq_ff <= '0;
         item_valid_ff <= 1'b0;
         point_x_ff <= '0;
         point_y_ff <= '0;
         point_z_ff <= '0;
         prev_hit_ff <= 1'b0;
         hits_ff <= '0;
         runs_ff <= '0;
         total_points_ff <= '0;
         total_covered_ff <= '0;
         largest_runs_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            radius_ff <= csr_wdata;
            radius_sq_ff <= SQ'(csr_wdata) * SQ'(csr_wdata);
         end
         item_valid_ff <= item_valid_in;
         point_x_ff <= point_x_in;
         point_y_ff <= point_y_in;
         point_z_ff <= point_z_in;
         prev_hit_ff <= prev_hit_in;
         hits_ff <= hits_in;
         runs_ff <= runs_in;
         total_points_ff <= total_points_in;
         total_covered_ff <= total_covered_in;
         largest_runs_ff <= largest_runs_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         item_func_ff <= req_chan.func;
         item_x_ff <= req_chan.pos_x;
         item_y_ff <= req_chan.pos_y;
         item_z_ff <= req_chan.pos_z;
      end
      if (item_go && is_end) begin
         rsp_covered_ff <= (hits_ff != '0);
         rsp_hits_ff <= hits_ff;
         rsp_runs_ff <= runs_ff;
         rsp_seen_ff <= total_points_in;
         rsp_hit_points_ff <= total_covered_in;
         rsp_max_runs_ff <= largest_runs_in;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.point_covered = rsp_covered_ff;
   assign rsp_chan.hit_count = rsp_hits_ff;
   assign rsp_chan.run_count = rsp_runs_ff;
   assign rsp_chan.points_seen = rsp_seen_ff;
   assign rsp_chan.points_hit = rsp_hit_points_ff;
   assign rsp_chan.max_runs = rsp_max_runs_ff;

   `TRCC_ASSERT_SAME(a_runs_within_hits, clock, reset, 1'b1, runs_ff <= hits_ff)
   `TRCC_ASSERT_SAME(a_covered_within_seen, clock, reset, 1'b1, total_covered_ff <= total_points_ff)
   `TRCC_ASSERT_NEXT(a_end_gives_response, clock, reset, item_go && is_end, rsp_valid_ff)
   `TRCC_ASSERT_SAME(a_response_max_runs, clock, reset, rsp_valid_ff, rsp_runs_ff <= rsp_max_runs_ff)

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// Tool radius coverage counter testbench
// Drives start, waypoint, end and clear requests through the request channel
// while a scoreboard class predicts each point summary. Checks every response
// field against the prediction under random stalls on both channels. Covers
// several radius settings and extreme coordinates.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import trcc_pkg::*;

   localparam int COORD_WIDTH = 24;
   localparam int COUNT_WIDTH = 16;
   localparam int TOTAL_WIDTH = 20;
   localparam int COORD_MAX = 8388607;
   localparam int COORD_MIN = -8388608;
   localparam int REQ_SIDE = 0;
   localparam int RSP_SIDE = 1;
   localparam int CYCLE_LIMIT = 1500000;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;

   typedef struct {
      coord_type x;
      coord_type y;
      coord_type z;
   } position_type;

   typedef struct {
      logic                   point_covered;
      logic [COUNT_WIDTH-1:0] hit_count;
      logic [COUNT_WIDTH-1:0] run_count;
      logic [TOTAL_WIDTH-1:0] points_seen;
      logic [TOTAL_WIDTH-1:0] points_hit;
      logic [COUNT_WIDTH-1:0] max_runs;
   } coverage_summary_type;

   class coverage_tally_type;
      logic [COORD_WIDTH-2:0] radius;
      position_type           centre;
      bit                     last_hit;
      logic [COUNT_WIDTH-1:0] hits;
      logic [COUNT_WIDTH-1:0] runs;
      logic [TOTAL_WIDTH-1:0] points_done;
      logic [TOTAL_WIDTH-1:0] points_covered;
      logic [COUNT_WIDTH-1:0] most_runs;
      coverage_summary_type   expected_summaries[$];
      int                     failures;

      function new();
         radius = '0;
         centre.x = '0;
         centre.y = '0;
         centre.z = '0;
         last_hit = 1'b0;
         hits = '0;
         runs = '0;
         points_done = '0;
         points_covered = '0;
         most_runs = '0;
         failures = 0;
      endfunction

      function bit in_reach(position_type w);
         longint dx;
         longint dy;
         longint dz;
         longint r;
         dx = longint'(w.x) - longint'(centre.x);
         dy = longint'(w.y) - longint'(centre.y);
         dz = longint'(w.z) - longint'(centre.z);
         if (dx < 0) dx = -dx;
         if (dy < 0) dy = -dy;
         if (dz < 0) dz = -dz;
         r = longint'(radius);
         if (dx > r || dy > r || dz > r) return 1'b0;
         return (dx * dx + dy * dy + dz * dz) <= r * r;
      endfunction

      function void take_request(func_type f, position_type p);
         bit                   hit;
         coverage_summary_type s;
         case (f)
            FUNC_START: begin
               centre = p;
               last_hit = 1'b0;
               hits = '0;
               runs = '0;
            end
            FUNC_WAYPOINT: begin
               hit = in_reach(p);
               if (hit) begin
                  if (hits != '1) hits = hits + 1'b1;
                  if (!last_hit && runs != '1) runs = runs + 1'b1;
               end
               last_hit = hit;
            end
            FUNC_CLEAR: begin
               points_done = '0;
               points_covered = '0;
               most_runs = '0;
            end
            FUNC_END: begin
               if (points_done != '1) points_done = points_done + 1'b1;
               if (hits != '0 && points_covered != '1) points_covered = points_covered + 1'b1;
               if (runs > most_runs) most_runs = runs;
               s.point_covered = (hits != '0);
               s.hit_count = hits;
               s.run_count = runs;
               s.points_seen = points_done;
               s.points_hit = points_covered;
               s.max_runs = most_runs;
               expected_summaries.insert(expected_summaries.size(), s);
            end
         endcase
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
         end
      endfunction

      function void check_summary(coverage_summary_type got);
         coverage_summary_type want;
         if (expected_summaries.size() == 0) begin
            $error("response arrived with no end request outstanding");
            failures++;
            return;
         end
         want = expected_summaries.pop_front();
         compare_field("point_covered", 32'(want.point_covered), 32'(got.point_covered));
         compare_field("hit_count", 32'(want.hit_count), 32'(got.hit_count));
         compare_field("run_count", 32'(want.run_count), 32'(got.run_count));
         compare_field("points_seen", 32'(want.points_seen), 32'(got.points_seen));
         compare_field("points_hit", 32'(want.points_hit), 32'(got.points_hit));
         compare_field("max_runs", 32'(want.max_runs), 32'(got.max_runs));
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_we;
   logic [COORD_WIDTH-2:0] csr_wdata;
   int                     cycle_count = 0;
   int                     items_sent = 0;
   bit                     calm [2];
   coverage_tally_type     tally = new();

   trcc_req_if #(.COORD_WIDTH(COORD_WIDTH)) req_chan ();
   trcc_rsp_if #(.COUNT_WIDTH(COUNT_WIDTH), .TOTAL_WIDTH(TOTAL_WIDTH)) rsp_chan ();

   tool_radius_coverage_counter_core #(
      .COORD_WIDTH(COORD_WIDTH),
      .COUNT_WIDTH(COUNT_WIDTH),
      .TOTAL_WIDTH(TOTAL_WIDTH)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .csr_we   (csr_we),
      .csr_wdata(csr_wdata),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   function automatic int draw_gap(int side);
      if ($urandom_range(0, 31) == 0) calm[side] = !calm[side];
      return calm[side] ? 0 : int'($urandom_range(0, 17));
   endfunction

   function automatic position_type make_position(int x, int y, int z);
      position_type p;
      p.x = coord_type'(x);
      p.y = coord_type'(y);
      p.z = coord_type'(z);
      return p;
   endfunction

   function automatic coord_type random_coord();
      case ($urandom_range(0, 11))
         0: return coord_type'(COORD_MIN);
         1: return coord_type'(COORD_MAX);
         2: return '0;
         3: return '1;
         default: return coord_type'($urandom);
      endcase
   endfunction

   function automatic position_type random_position();
      position_type p;
      p.x = random_coord();
      p.y = random_coord();
      p.z = random_coord();
      return p;
   endfunction

   function automatic coord_type near_coord(int centre, int span);
      int v;
      v = centre + int'($urandom_range(0, 2 * span)) - span;
      if (v > COORD_MAX) v = COORD_MAX;
      if (v < COORD_MIN) v = COORD_MIN;
      return coord_type'(v);
   endfunction

   function automatic position_type pick_waypoint(position_type p, int r);
      position_type w;
      int           kind;
      int           off;
      kind = $urandom_range(0, 9);
      w = p;
      if (kind <= 6) begin
         w.x = near_coord(int'(p.x), (kind <= 3) ? r / 2 : r);
         w.y = near_coord(int'(p.y), (kind <= 3) ? r / 2 : r);
         w.z = near_coord(int'(p.z), (kind <= 3) ? r / 2 : r);
      end else if (kind == 7) begin
         off = r + int'($urandom_range(0, 1));
         if ($urandom_range(0, 1) == 1) off = -off;
         case ($urandom_range(0, 2))
            0: w.x = near_coord(int'(p.x) + off, 0);
            1: w.y = near_coord(int'(p.y) + off, 0);
            default: w.z = near_coord(int'(p.z) + off, 0);
         endcase
      end else if (kind == 9) begin
         w = random_position();
      end
      return w;
   endfunction

   task automatic send_request(func_type f, position_type p);
      int gap;
      gap = draw_gap(REQ_SIDE);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.func <= f;
      req_chan.pos_x <= p.x;
      req_chan.pos_y <= p.y;
      req_chan.pos_z <= p.z;
      do @(posedge clock); while (!req_chan.ready);
      tally.take_request(f, p);
      items_sent++;
   endtask

   task automatic settle();
      req_chan.valid <= 1'b0;
      while (tally.expected_summaries.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_radius(logic [COORD_WIDTH-2:0] r);
      csr_we <= 1'b1;
      csr_wdata <= r;
      @(posedge clock);
      csr_we <= 1'b0;
      tally.radius = r;
   endtask

   task automatic random_phase(int count);
      int           target;
      int           n;
      position_type p;
      target = items_sent + count;
      while (items_sent < target) begin
         if ($urandom_range(0, 9) == 0) begin
            send_request(func_type'($urandom_range(0, 3)), random_position());
         end else begin
            p = random_position();
            send_request(FUNC_START, p);
            n = $urandom_range(0, 12);
            repeat (n) send_request(FUNC_WAYPOINT, pick_waypoint(p, int'(tally.radius)));
            send_request(FUNC_END, random_position());
         end
      end
   endtask

   initial begin : drain_results
      coverage_summary_type got;
      int                   gap;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         gap = draw_gap(RSP_SIDE);
         if (gap > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
         got.point_covered = rsp_chan.point_covered;
         got.hit_count = rsp_chan.hit_count;
         got.run_count = rsp_chan.run_count;
         got.points_seen = rsp_chan.points_seen;
         got.points_hit = rsp_chan.points_hit;
         got.max_runs = rsp_chan.max_runs;
         tally.check_summary(got);
      end
   end

   initial begin : stimulus
      logic [COORD_WIDTH-2:0] r;
      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_wdata <= '0;
      req_chan.valid <= 1'b0;
      req_chan.func <= FUNC_START;
      req_chan.pos_x <= '0;
      req_chan.pos_y <= '0;
      req_chan.pos_z <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      write_radius((COORD_WIDTH-1)'(5));
      send_request(FUNC_WAYPOINT, make_position(0, 0, 0));
      send_request(FUNC_WAYPOINT, make_position(5, 0, 0));
      send_request(FUNC_WAYPOINT, make_position(6, 0, 0));
      send_request(FUNC_WAYPOINT, make_position(0, 3, 4));
      send_request(FUNC_WAYPOINT, make_position(3, 4, 1));
      send_request(FUNC_END, make_position(0, 0, 0));
      send_request(FUNC_END, make_position(COORD_MAX, COORD_MIN, -1));
      send_request(FUNC_START, make_position(COORD_MAX, COORD_MAX, COORD_MAX));
      send_request(FUNC_WAYPOINT, make_position(COORD_MIN, COORD_MIN, COORD_MIN));
      send_request(FUNC_WAYPOINT, make_position(COORD_MAX, COORD_MAX, COORD_MAX));
      send_request(FUNC_END, make_position(0, 0, 0));
      send_request(FUNC_START, make_position(COORD_MIN, COORD_MIN, COORD_MIN));
      send_request(FUNC_WAYPOINT, make_position(COORD_MIN, COORD_MIN, COORD_MIN));
      send_request(FUNC_WAYPOINT, make_position(COORD_MAX, COORD_MIN, COORD_MIN));
      send_request(FUNC_WAYPOINT, make_position(COORD_MIN + 3, COORD_MIN, COORD_MIN + 4));
      send_request(FUNC_END, make_position(0, 0, 0));
      send_request(FUNC_CLEAR, make_position(0, 0, 0));
      send_request(FUNC_END, make_position(0, 0, 0));
      send_request(FUNC_START, make_position(-1, 0, 1));
      send_request(FUNC_END, make_position(0, 0, 0));
      send_request(FUNC_CLEAR, make_position(COORD_MAX, COORD_MAX, COORD_MAX));
      send_request(FUNC_START, make_position(-1, -1, -1));
      send_request(FUNC_WAYPOINT, make_position(-1, 4, -1));
      send_request(FUNC_END, make_position(0, 0, 0));
      settle();

      for (int i = 0; i < 4; i++) begin
         case (i)
            0: r = '1;
            1: r = '0;
            2: r = (COORD_WIDTH-1)'($urandom);
            default: r = (COORD_WIDTH-1)'($urandom_range(1, 300));
         endcase
         write_radius(r);
         random_phase(375);
         settle();
      end

      if (tally.failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule
